[sv/stsc_pkg.sv]
// stsc_pkg: shared types and codes of the source token scanner
// token and run records, action codes, scan modes, token kind codes
// no dependencies
package stsc_pkg;

    localparam int KEYWORD_SLOTS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int MAX_RUN           = 3;
    localparam int QUEUE_DEPTH       = 4;   // power of two
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_END  = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        M_IDLE, M_NAME, M_BADWORD, M_DEC, M_BIN, M_OCT, M_HEX,
        M_STRING, M_CHAR, M_COMMENT, M_ENDED
    } t_mode;

    localparam logic [1:0] CLS_ARMS  = 2'd1;
    localparam logic [1:0] CLS_BLOCK = 2'd2;

    localparam logic [5:0] K_ILLEGAL = 6'd0;
    localparam logic [5:0] K_NAME    = 6'd1;
    localparam logic [5:0] K_KEYWORD = 6'd2;
    localparam logic [5:0] K_DEC     = 6'd3;
    localparam logic [5:0] K_FLOAT   = 6'd4;
    localparam logic [5:0] K_BIN     = 6'd5;
    localparam logic [5:0] K_OCT     = 6'd6;
    localparam logic [5:0] K_HEX     = 6'd7;
    localparam logic [5:0] K_STRING  = 6'd8;
    localparam logic [5:0] K_CHAR    = 6'd9;
    localparam logic [5:0] K_COMMENT = 6'd10;
    localparam logic [5:0] K_TERM    = 6'd11;
    localparam logic [5:0] K_END     = 6'd12;
    localparam logic [5:0] K_LPAREN  = 6'd13;
    localparam logic [5:0] K_RPAREN  = 6'd14;
    localparam logic [5:0] K_LBRACE  = 6'd15;
    localparam logic [5:0] K_RBRACE  = 6'd16;
    localparam logic [5:0] K_LBRACK  = 6'd17;
    localparam logic [5:0] K_RBRACK  = 6'd18;
    localparam logic [5:0] K_LT      = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_GT      = 6'd21;
    localparam logic [5:0] K_GE      = 6'd22;
    localparam logic [5:0] K_PLUS    = 6'd23;
    localparam logic [5:0] K_PLUSEQ  = 6'd24;
    localparam logic [5:0] K_INC     = 6'd25;
    localparam logic [5:0] K_MINUS   = 6'd26;
    localparam logic [5:0] K_MINUSEQ = 6'd27;
    localparam logic [5:0] K_DECR    = 6'd28;
    localparam logic [5:0] K_COMMA   = 6'd29;
    localparam logic [5:0] K_ASSIGN  = 6'd30;
    localparam logic [5:0] K_EQ      = 6'd31;
    localparam logic [5:0] K_COLON   = 6'd32;
    localparam logic [5:0] K_DEFINE  = 6'd33;
    localparam logic [5:0] K_SEMI    = 6'd34;
    localparam logic [5:0] K_DOT     = 6'd35;
    localparam logic [5:0] K_PERCENT = 6'd36;
    localparam logic [5:0] K_STAR    = 6'd37;
    localparam logic [5:0] K_AMP     = 6'd38;
    localparam logic [5:0] K_ANDAND  = 6'd39;
    localparam logic [5:0] K_SLASH   = 6'd40;
    localparam logic [5:0] K_BANG    = 6'd41;
    localparam logic [5:0] K_NE      = 6'd42;
    localparam logic [5:0] K_BAR     = 6'd43;
    localparam logic [5:0] K_OROR    = 6'd44;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] line;
        logic [31:0] offset;
    } t_pos;

    typedef struct packed {
        logic [5:0]  kind;
        logic [3:0]  kwi;
        t_pos        start;
        logic [15:0] len;
    } t_tok;

    typedef struct packed {
        logic [1:0]               cnt;
        t_tok [MAX_RUN-1:0]       tok;
    } t_run;

endpackage

[sv/source_token_scanner.sv]
// source_token_scanner: top level of the streaming source token scanner
// front classifier feeding a run queue that serializes tokens
// depends on stsc_pkg, stsc_front, stsc_queue
//
// Streaming lexer. Each input beat is a source byte, an end-of-input mark, or a
// keyword table load; the table must be loaded before scanning since keywords
// are not built in. Tokens come out in source order with kind, keyword slot,
// start offset, length, line and column; last_of_run marks the final token a
// beat produced (a beat makes zero to three tokens). A terminator token is
// inserted after a name or arming keyword at newline, '}', '//' or end unless
// a blocking keyword came first ('{' lifts the block). Timing: the front takes
// one beat per cycle while full is low, every keyword slot compared in parallel
// against the collected name; the back hands out one token per cycle while pop
// is held, from a four-run queue. The sustained input rate is one beat per cycle
// while results drain at least as fast as they are made; a beat closing several
// tokens needs one pop per token. full rises only while the run queue is full.
module source_token_scanner import stsc_pkg::*; #(
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_byte_value,
    input  logic [3:0]  i_keyword_slot,
    input  logic [63:0] i_keyword_text,
    input  logic [3:0]  i_keyword_length,
    input  logic [1:0]  i_keyword_class,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [3:0]  o_keyword_index,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_of_run
);

    logic w_accept;
    t_run w_run;
    logic w_run_valid;
    t_tok w_tok;

    // beat accepted whenever the run queue has a free slot
    assign w_accept = push && !full;

    stsc_front #(
        .KEYWORD_SLOTS(KEYWORD_SLOTS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_accept),
        .i_action        (i_action),
        .i_byte_value    (i_byte_value),
        .i_keyword_slot  (i_keyword_slot),
        .i_keyword_text  (i_keyword_text),
        .i_keyword_length(i_keyword_length),
        .i_keyword_class (i_keyword_class),
        .o_run           (w_run),
        .o_run_valid     (w_run_valid)
    );

    stsc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_run_valid),
        .i_run  (w_run),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_tok  (w_tok),
        .o_last (o_last_of_run)
    );

    assign o_token_kind    = w_tok.kind;
    assign o_keyword_index = w_tok.kwi;
    assign o_start_offset  = w_tok.start.offset;
    assign o_token_length  = w_tok.len;
    assign o_line_number   = w_tok.start.line;
    assign o_column_number = w_tok.start.col;

endmodule

[sv/stsc_front.sv]
// stsc_front: byte classifier and scan state of the source token scanner
// takes one beat per cycle, produces the run of tokens it closes
// depends on stsc_pkg
module stsc_front import stsc_pkg::*; #(
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_byte_value,
    input  logic [3:0]  i_keyword_slot,
    input  logic [63:0] i_keyword_text,
    input  logic [3:0]  i_keyword_length,
    input  logic [1:0]  i_keyword_class,
    output t_run        o_run,
    output logic        o_run_valid
);

    localparam int SLOT_W = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;

    function automatic logic f_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic f_alnum(input logic [7:0] c);
        return f_alpha(c) || f_digit(c);
    endfunction

    function automatic logic f_radix(input t_mode m, input logic [7:0] c);
        logic r;
        case (m)
            M_BIN:   r = c == "0" || c == "1";
            M_OCT:   r = c >= "0" && c <= "7";
            default: r = f_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_lone(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            ",":     k = K_COMMA;
            "=":     k = K_ASSIGN;
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            ".":     k = K_DOT;
            "%":     k = K_PERCENT;
            "*":     k = K_STAR;
            "&":     k = K_AMP;
            "/":     k = K_SLASH;
            "!":     k = K_BANG;
            "|":     k = K_BAR;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic f_lead(input logic [7:0] c);
        return c == "<" || c == ">" || c == "+" || c == "-" || c == "=" ||
               c == ":" || c == "&" || c == "!" || c == "|";
    endfunction

    function automatic logic [5:0] f_pair(input logic [7:0] p, input logic [7:0] n);
        logic [5:0] k;
        k = K_ILLEGAL;
        if (n == "=") begin
            case (p)
                "<":     k = K_LE;
                ">":     k = K_GE;
                "+":     k = K_PLUSEQ;
                "-":     k = K_MINUSEQ;
                "=":     k = K_EQ;
                ":":     k = K_DEFINE;
                "!":     k = K_NE;
                default: k = K_ILLEGAL;
            endcase
        end else if (p == "+" && n == "+") begin
            k = K_INC;
        end else if (p == "-" && n == "-") begin
            k = K_DECR;
        end else if (p == "&" && n == "&") begin
            k = K_ANDAND;
        end else if (p == "|" && n == "|") begin
            k = K_OROR;
        end
        return k;
    endfunction

    function automatic t_pos f_adv(input t_pos p, input logic [7:0] c);
        t_pos r;
        r = p;
        r.offset = p.offset + 32'd1;
        if (c == 8'h0a) begin
            r.line = (p.line != 16'hffff) ? p.line + 16'd1 : p.line;
            r.col  = 16'd1;
        end else begin
            r.col = (p.col != 16'hffff) ? p.col + 16'd1 : p.col;
        end
        return r;
    endfunction

    function automatic t_run f_put(input t_run r, input logic [5:0] kind,
                                   input logic [3:0] kwi, input t_pos start,
                                   input logic [15:0] len);
        t_run o;
        o = r;
        if (r.cnt != 2'd3) begin
            o.tok[r.cnt] = '{kind: kind, kwi: kwi, start: start, len: len};
            o.cnt = r.cnt + 2'd1;
        end
        return o;
    endfunction

    function automatic logic [15:0] f_span(input t_pos s, input t_pos p);
        logic [31:0] d;
        d = p.offset - s.offset;
        return (d > 32'd65535) ? 16'hffff : d[15:0];
    endfunction

    // keyword table
    logic [63:0] r_kw_text [KEYWORD_SLOTS];
    logic [3:0]  r_kw_len  [KEYWORD_SLOTS];
    logic [1:0]  r_kw_cls  [KEYWORD_SLOTS];

    // scan state
    t_mode       r_mode,  n_mode;
    logic [8:0]  r_prev,  n_prev;
    logic [8:0]  r_pend,  n_pend;
    t_pos        r_pos,   n_pos;
    t_pos        r_tstart, n_tstart;
    logic [63:0] r_nbuf,  n_nbuf;
    logic [3:0]  r_ncnt,  n_ncnt;
    logic        r_nflag, n_nflag;
    logic        r_armed, n_armed;
    logic        r_blocked, n_blocked;
    t_run        w_run;

    logic              w_hit;
    logic [SLOT_W-1:0] w_hit_idx;
    logic [1:0]        w_hit_cls;
    logic [SLOT_W-1:0] w_slot;
    logic [3:0]        w_len;
    logic [63:0]       w_mask;

    // parallel keyword compare, lowest slot wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
            if (r_kw_len[i] == r_ncnt && r_kw_text[i] == r_nbuf) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
        end
        if (r_ncnt == 4'd0 || 32'(r_ncnt) > KEYWORD_CHARS) begin
            w_hit = 1'b0;
        end
        w_hit_cls = r_kw_cls[w_hit_idx];
    end

    always_comb begin
        logic [8:0]  v_n;
        logic [7:0]  v_c;
        logic [7:0]  v_p;
        logic        v_isb;
        logic        v_took;
        logic [5:0]  v_k;
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_pend    = r_pend;
        n_pos     = r_pos;
        n_tstart  = r_tstart;
        n_nbuf    = r_nbuf;
        n_ncnt    = r_ncnt;
        n_nflag   = r_nflag;
        n_armed   = r_armed;
        n_blocked = r_blocked;
        w_run     = '0;
        v_n       = (t_action'(i_action) == ACT_END) ? 9'h100 : {1'b0, i_byte_value};
        v_c       = v_n[7:0];
        v_isb     = !v_n[8];
        v_took    = 1'b0;
        v_p       = r_pend[7:0];
        v_k       = K_ILLEGAL;

        if (r_mode == M_ENDED) begin
            if (t_action'(i_action) == ACT_END) begin
                w_run = f_put(w_run, K_END, 4'd0, n_pos, 16'd0);
            end
        end else begin
            // held byte decided by this beat
            if (r_pend[8]) begin
                n_pend = '0;
                if (v_p == "0") begin
                    if (v_isb && (v_c == "b" || v_c == "o" || v_c == "x")) begin
                        n_pos  = f_adv(f_adv(n_pos, v_p), v_c);
                        n_prev = {1'b0, v_c};
                        n_mode = (v_c == "b") ? M_BIN : ((v_c == "o") ? M_OCT : M_HEX);
                        n_nflag = 1'b0;
                        v_took = 1'b1;
                    end else begin
                        n_pos  = f_adv(n_pos, v_p);
                        n_prev = {1'b0, v_p};
                        if (v_isb && v_c == ".") begin
                            n_mode  = M_DEC;
                            n_nflag = 1'b0;
                        end else if (v_isb && f_alnum(v_c)) begin
                            n_mode = M_BADWORD;
                        end else begin
                            w_run = f_put(w_run, K_DEC, 4'd0, n_tstart, f_span(n_tstart, n_pos));
                        end
                    end
                end else if (v_p == "/") begin
                    if (v_isb && v_c == "/") begin
                        if (n_armed) begin
                            w_run   = f_put(w_run, K_TERM, 4'd0, n_pos, 16'd0);
                            n_armed = 1'b0;
                        end
                        n_pos  = f_adv(n_pos, v_p);
                        n_prev = {1'b0, v_p};
                        n_mode = M_COMMENT;
                    end else begin
                        n_pos  = f_adv(n_pos, v_p);
                        n_prev = {1'b0, v_p};
                        w_run  = f_put(w_run, K_SLASH, 4'd0, n_tstart, f_span(n_tstart, n_pos));
                    end
                end else begin
                    v_k    = v_isb ? f_pair(v_p, v_c) : K_ILLEGAL;
                    n_pos  = f_adv(n_pos, v_p);
                    n_prev = {1'b0, v_p};
                    if (v_k != K_ILLEGAL) begin
                        n_pos  = f_adv(n_pos, v_c);
                        n_prev = {1'b0, v_c};
                        w_run  = f_put(w_run, v_k, 4'd0, n_tstart, f_span(n_tstart, n_pos));
                        v_took = 1'b1;
                    end else begin
                        w_run = f_put(w_run, f_lone(v_p), 4'd0, n_tstart,
                                      f_span(n_tstart, n_pos));
                    end
                end
            end

            // continue the open token
            if (!v_took && n_mode != M_IDLE) begin
                case (n_mode)
                    M_NAME: begin
                        if (v_isb && f_alnum(v_c)) begin
                            if (32'(n_ncnt) < KEYWORD_CHARS) begin
                                n_nbuf = n_nbuf | ({56'd0, v_c} << {n_ncnt, 3'b000});
                                n_ncnt = n_ncnt + 4'd1;
                            end else begin
                                n_ncnt = 4'(KEYWORD_CHARS + 1);
                            end
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else begin
                            if ((!w_hit || w_hit_cls == CLS_ARMS) && !n_blocked) begin
                                n_armed = 1'b1;
                            end
                            if (w_hit && w_hit_cls == CLS_BLOCK) begin
                                n_armed   = 1'b0;
                                n_blocked = 1'b1;
                            end
                            w_run = f_put(w_run, w_hit ? K_KEYWORD : K_NAME,
                                          w_hit ? 4'(w_hit_idx) : 4'd0,
                                          n_tstart, f_span(n_tstart, n_pos));
                        end
                    end
                    M_BADWORD: begin
                        if (v_isb && f_alnum(v_c)) begin
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else begin
                            w_run = f_put(w_run, K_ILLEGAL, 4'd0, n_tstart,
                                          f_span(n_tstart, n_pos));
                        end
                    end
                    M_DEC: begin
                        if (v_isb && v_c == "." && !n_nflag) begin
                            n_nflag = 1'b1;
                            n_pos   = f_adv(n_pos, v_c);
                            n_prev  = {1'b0, v_c};
                            v_took  = 1'b1;
                        end else if (v_isb && f_digit(v_c)) begin
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else if (v_isb && (f_alnum(v_c) || v_c == ".")) begin
                            n_mode = M_BADWORD;
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else begin
                            w_run = f_put(w_run,
                                          (n_prev == 9'h02e) ? K_ILLEGAL :
                                          (n_nflag ? K_FLOAT : K_DEC),
                                          4'd0, n_tstart, f_span(n_tstart, n_pos));
                        end
                    end
                    M_BIN, M_OCT, M_HEX: begin
                        if (v_isb && f_radix(n_mode, v_c)) begin
                            n_nflag = 1'b1;
                            n_pos   = f_adv(n_pos, v_c);
                            n_prev  = {1'b0, v_c};
                            v_took  = 1'b1;
                        end else if (v_isb && f_alnum(v_c)) begin
                            n_mode = M_BADWORD;
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else begin
                            w_run = f_put(w_run,
                                          !n_nflag ? K_ILLEGAL :
                                          (n_mode == M_BIN) ? K_BIN :
                                          ((n_mode == M_OCT) ? K_OCT : K_HEX),
                                          4'd0, n_tstart, f_span(n_tstart, n_pos));
                        end
                    end
                    M_STRING, M_CHAR: begin
                        if (!v_isb) begin
                            w_run = f_put(w_run, K_ILLEGAL, 4'd0, n_tstart,
                                          f_span(n_tstart, n_pos));
                        end else if ((n_mode == M_STRING && v_c == "\"" &&
                                      n_prev != 9'h05c) ||
                                     (n_mode == M_CHAR && v_c == "'")) begin
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            w_run  = f_put(w_run, (n_mode == M_STRING) ? K_STRING : K_CHAR,
                                           4'd0, n_tstart, f_span(n_tstart, n_pos));
                            n_mode = M_IDLE;
                            v_took = 1'b1;
                        end else begin
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (v_isb && v_c != 8'h0a) begin
                            n_pos  = f_adv(n_pos, v_c);
                            n_prev = {1'b0, v_c};
                            v_took = 1'b1;
                        end else begin
                            w_run = f_put(w_run, K_COMMENT, 4'd0, n_tstart,
                                          f_span(n_tstart, n_pos));
                            if (v_isb) begin
                                n_pos  = f_adv(n_pos, v_c);
                                n_prev = {1'b0, v_c};
                                n_mode = M_IDLE;
                                v_took = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (!v_took) begin
                    n_mode = M_IDLE;
                end
            end

            // start of a new token, or the end
            if (!v_took) begin
                if (!v_isb) begin
                    if (n_armed) begin
                        w_run   = f_put(w_run, K_TERM, 4'd0, n_pos, 16'd0);
                        n_armed = 1'b0;
                    end
                    w_run  = f_put(w_run, K_END, 4'd0, n_pos, 16'd0);
                    n_mode = M_ENDED;
                end else if (v_c == " " || (v_c == 8'h0a && !n_armed)) begin
                    n_pos  = f_adv(n_pos, v_c);
                    n_prev = {1'b0, v_c};
                end else if (v_c == 8'h0a) begin
                    w_run   = f_put(w_run, K_TERM, 4'd0, n_pos, 16'd0);
                    n_armed = 1'b0;
                    n_pos   = f_adv(n_pos, v_c);
                    n_prev  = {1'b0, v_c};
                end else begin
                    if (n_armed && v_c == "}") begin
                        w_run   = f_put(w_run, K_TERM, 4'd0, n_pos, 16'd0);
                        n_armed = 1'b0;
                    end
                    n_tstart = n_pos;
                    if (f_alpha(v_c)) begin
                        n_mode = M_NAME;
                        n_nbuf = {56'd0, v_c};
                        n_ncnt = 4'd1;
                        n_pos  = f_adv(n_pos, v_c);
                        n_prev = {1'b0, v_c};
                    end else if (v_c >= "1" && v_c <= "9") begin
                        n_mode  = M_DEC;
                        n_nflag = 1'b0;
                        n_pos   = f_adv(n_pos, v_c);
                        n_prev  = {1'b0, v_c};
                    end else if (v_c == "0" || v_c == "/" || f_lead(v_c)) begin
                        n_pend = {1'b1, v_c};
                    end else if (v_c == "\"" || v_c == "'") begin
                        n_mode = (v_c == "\"") ? M_STRING : M_CHAR;
                        n_pos  = f_adv(n_pos, v_c);
                        n_prev = {1'b0, v_c};
                    end else begin
                        if (v_c == "{") begin
                            n_blocked = 1'b0;
                        end
                        n_pos  = f_adv(n_pos, v_c);
                        n_prev = {1'b0, v_c};
                        w_run  = f_put(w_run, f_lone(v_c), 4'd0, n_tstart,
                                       f_span(n_tstart, n_pos));
                    end
                end
            end
        end
    end

    // keyword load: long keyword empties the slot, padding masked off
    always_comb begin
        w_slot = SLOT_W'(i_keyword_slot);
        w_len  = (32'(i_keyword_length) > KEYWORD_CHARS) ? 4'd0 : i_keyword_length;
        for (int i = 0; i < 8; i++) begin
            w_mask[i*8 +: 8] = (4'(i) < w_len) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEYWORD_SLOTS; i++) begin
                r_kw_len[i] <= 4'd0;
            end
        end else if (i_valid && t_action'(i_action) == ACT_LOAD &&
                     32'(i_keyword_slot) < KEYWORD_SLOTS) begin
            r_kw_len[w_slot] <= w_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && t_action'(i_action) == ACT_LOAD &&
            32'(i_keyword_slot) < KEYWORD_SLOTS) begin
            r_kw_text[w_slot] <= i_keyword_text & w_mask;
            r_kw_cls[w_slot]  <= i_keyword_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_prev    <= 9'h100;
            r_pend    <= '0;
            r_pos     <= '{col: 16'd1, line: 16'd1, offset: 32'd0};
            r_tstart  <= '0;
            r_nbuf    <= '0;
            r_ncnt    <= 4'd0;
            r_nflag   <= 1'b0;
            r_armed   <= 1'b0;
            r_blocked <= 1'b0;
        end else if (i_valid && (t_action'(i_action) == ACT_BYTE ||
                                 t_action'(i_action) == ACT_END)) begin
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_pend    <= n_pend;
            r_pos     <= n_pos;
            r_tstart  <= n_tstart;
            r_nbuf    <= n_nbuf;
            r_ncnt    <= n_ncnt;
            r_nflag   <= n_nflag;
            r_armed   <= n_armed;
            r_blocked <= n_blocked;
        end
    end

    assign o_run       = w_run;
    assign o_run_valid = i_valid && (t_action'(i_action) == ACT_BYTE ||
                                     t_action'(i_action) == ACT_END) &&
                         w_run.cnt != 2'd0;

endmodule

[sv/stsc_queue.sv]
// stsc_queue: run queue and token serializer of the source token scanner
// holds runs of up to three tokens, hands them out one token at a time
// depends on stsc_pkg
module stsc_queue import stsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_tok o_tok,
    output logic o_last
);

    t_run                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic [1:0]          r_idx, n_idx;
    t_run                w_head;
    logic                w_take;

    assign w_head  = r_mem[r_rd];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_tok   = w_head.tok[r_idx];
    assign o_last  = r_idx == w_head.cnt - 2'd1;
    assign w_take  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_idx   = r_idx;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (w_take) begin
            if (o_last) begin
                n_rd  = r_rd + 1'b1;
                n_idx = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        n_count = r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(w_take && o_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_idx   <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("run queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("run pushed into full queue");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (w_head.cnt != 2'd0 && r_idx < w_head.cnt))
        else $error("head run index out of range");

    a_mid_run_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_last && !i_push) |=> (r_count == $past(r_count)))
        else $error("queue count moved inside a run");

endmodule
